>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared widths, reset values, register indexes and types of the piezo
// onset sample trigger.
// ----------------------------------------------------------------------------
package pst_pkg;

	// Default sizes
	localparam int STORE_DEPTH_DEF = 65536;
	localparam int FRAC_BITS_DEF   = 22;

	// Field and register widths
	localparam int SMP_W    = 16;
	localparam int WORD_W   = 16;
	localparam int POLE_W   = 16;
	localparam int LVL_W    = 23;
	localparam int LEN_W    = 17;
	localparam int PEAK_W   = 24;
	localparam int DATA_W   = 48;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	// Output queue depth
	localparam int OFIFO_DEPTH = 8;

	// Register reset values
	localparam logic [POLE_W-1:0] POLE_RST   = 16'd64881;
	localparam logic [LVL_W-1:0]  THR_RST    = 23'd4194;
	localparam logic [LVL_W-1:0]  MARGIN_RST = 23'd4194;
	localparam logic [LVL_W-1:0]  DECAY_RST  = 23'd210;
	localparam logic [LEN_W-1:0]  LEN_RST    = 17'd0;

	// Item kinds carried in tuser
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_LOAD   = 1'b1;

	// Register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_POLE   = 3'd0,
		REG_THR    = 3'd1,
		REG_MARGIN = 3'd2,
		REG_DECAY  = 3'd3,
		REG_LEN    = 3'd4
	} reg_idx_t;

	// Item payload travelling down the pipeline
	typedef struct packed {
		logic              load;
		logic [SMP_W-1:0]  addr;
		logic [WORD_W-1:0] value;
	} item_t;

	// Detector result handed to the playback stage
	typedef struct packed {
		logic              onset;
		logic [PEAK_W-1:0] peak;
	} det_t;

	// Result item, audio word in the lowest bits
	typedef struct packed {
		logic [PEAK_W-1:0] peak_level;
		logic              onset;
		logic              playing;
		logic [WORD_W-1:0] audio_word;
	} res_t;

endpackage

>>> hdl/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hdl/pst_dc_filter.sv
// ----------------------------------------------------------------------------
// pst_dc_filter
// Input stage and first-order DC blocker y = x - x_prev + pole*y_prev with
// saturation to the signed signal range.
// ----------------------------------------------------------------------------
module pst_dc_filter #(
	parameter int FRAC_BITS = pst_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  logic                             action,
	input  logic [pst_pkg::SMP_W-1:0]        piezo_sample,
	input  logic [pst_pkg::SMP_W-1:0]        load_address,
	input  logic [pst_pkg::WORD_W-1:0]       load_value,
	input  logic [pst_pkg::POLE_W-1:0]       dc_pole,
	output logic                             vld_s2,
	output pst_pkg::item_t                   itm_s2,
	output logic signed [FRAC_BITS+2:0]      y_q
);

	localparam int SW   = FRAC_BITS + 3;
	localparam int SUMW = SW + 2;
	localparam int SH   = FRAC_BITS - 16;
	localparam logic signed [SUMW-1:0] SIG_MAX = {3'b000, {(SW-1){1'b1}}};
	localparam logic signed [SUMW-1:0] SIG_MIN = {3'b111, {(SW-1){1'b0}}};

	logic                       vld_s1;
	pst_pkg::item_t             itm_s1;
	logic [pst_pkg::SMP_W-1:0]  smp_s1;
	logic [pst_pkg::SMP_W-1:0]  prev_q;

	logic [SW-1:0]              ymag;
	logic [SW+15:0]             prod;
	logic [SW-1:0]              prod_sh;
	logic signed [SUMW-1:0]     x_e;
	logic signed [SUMW-1:0]     xp_e;
	logic signed [SUMW-1:0]     fb_mag;
	logic signed [SUMW-1:0]     fb_e;
	logic signed [SUMW-1:0]     sum;
	logic signed [SW-1:0]       y_new;
	logic                       smp_go;

	// Hold the accepted item for the filter stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			itm_s1.load  <= (action == pst_pkg::ACT_LOAD);
			itm_s1.addr  <= load_address;
			itm_s1.value <= load_value;
			smp_s1       <= piezo_sample;
		end
	end

	// Sign-magnitude feedback product, truncated toward zero
	always_comb begin
		ymag    = y_q[SW-1] ? unsigned'(SW'(-y_q)) : unsigned'(y_q);
		prod    = (SW+16)'(ymag) * (SW+16)'(dc_pole);
		prod_sh = prod[SW+15:16];
		fb_mag  = $signed(SUMW'(prod_sh));
		fb_e    = y_q[SW-1] ? -fb_mag : fb_mag;
		x_e     = $signed(SUMW'(smp_s1) << SH);
		xp_e    = $signed(SUMW'(prev_q) << SH);
		sum     = x_e - xp_e + fb_e;
	end

	// Saturate to the signal range
	always_comb begin
		if (sum > SIG_MAX) begin
			y_new = SIG_MAX[SW-1:0];
		end else if (sum < SIG_MIN) begin
			y_new = SIG_MIN[SW-1:0];
		end else begin
			y_new = sum[SW-1:0];
		end
	end

	assign smp_go = vld_s1 && !itm_s1.load;

	// Advance filter state on sample items only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			y_q    <= '0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			if (smp_go) begin
				prev_q <= smp_s1;
				y_q    <= y_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		itm_s2 <= itm_s1;
	end

endmodule

>>> hdl/pst_peak_track.sv
// ----------------------------------------------------------------------------
// pst_peak_track
// Full-wave rectifier, decaying peak tracker and once-per-peak onset
// detector.
// ----------------------------------------------------------------------------
module pst_peak_track #(
	parameter int FRAC_BITS = pst_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_s2,
	input  pst_pkg::item_t                itm_s2,
	input  logic signed [FRAC_BITS+2:0]   y,
	input  logic [pst_pkg::LVL_W-1:0]     onset_threshold,
	input  logic [pst_pkg::LVL_W-1:0]     drop_margin,
	input  logic [pst_pkg::LVL_W-1:0]     peak_decay,
	output logic                          vld_s3,
	output pst_pkg::item_t                itm_s3,
	output pst_pkg::det_t                 det_s3
);

	localparam int SW = FRAC_BITS + 3;
	localparam int LW = FRAC_BITS + 2;
	localparam int CW = ((LW > pst_pkg::LVL_W) ? LW : pst_pkg::LVL_W) + 1;

	logic [SW-1:0] ymag;
	logic [LW-1:0] level;
	logic [LW-1:0] peak_q;
	logic [LW-1:0] peak_n;
	logic          fired_q;
	logic          fired_n;
	logic          fire;
	logic          smp_go;

	// Rectify and saturate
	always_comb begin
		ymag  = y[SW-1] ? unsigned'(SW'(-y)) : unsigned'(y);
		level = ymag[SW-1] ? {LW{1'b1}} : ymag[LW-1:0];
	end

	// Follow rises, otherwise decay while the step fits
	always_comb begin
		peak_n  = peak_q;
		fired_n = fired_q;
		if (level >= peak_q) begin
			peak_n  = level;
			fired_n = 1'b0;
		end else if (CW'(peak_q) >= CW'(peak_decay)) begin
			peak_n = peak_q - LW'(peak_decay);
		end
		fire = (CW'(level) + CW'(drop_margin) < CW'(peak_n)) &&
		       (CW'(peak_n) >= CW'(onset_threshold)) && !fired_n;
	end

	assign smp_go = vld_s2 && !itm_s2.load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			fired_q <= 1'b0;
			vld_s3  <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			if (smp_go) begin
				peak_q  <= peak_n;
				fired_q <= fired_n || fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		itm_s3       <= itm_s2;
		det_s3.onset <= fire;
		det_s3.peak  <= pst_pkg::PEAK_W'(peak_n);
	end

endmodule

>>> hdl/pst_playback.sv
// ----------------------------------------------------------------------------
// pst_playback
// Playback sequencer over the sample store: loads write the store, onsets
// restart the read index, sample items read one word each while playing.
// ----------------------------------------------------------------------------
module pst_playback #(
	parameter int STORE_DEPTH = pst_pkg::STORE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_s3,
	input  pst_pkg::item_t              itm_s3,
	input  pst_pkg::det_t               det_s3,
	input  logic [pst_pkg::LEN_W-1:0]   sample_length,
	output logic                        res_vld,
	output pst_pkg::res_t               res
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic [pst_pkg::LEN_W-1:0]  idx_q;
	logic                       active_q;
	logic                       act;
	logic [pst_pkg::LEN_W-1:0]  idx0;
	logic [pst_pkg::LEN_W-1:0]  idx_inc;
	logic                       stop;
	logic                       smp_go;
	logic                       rd_en;
	logic                       we;
	logic [AW-1:0]              ram_addr;
	logic [pst_pkg::WORD_W-1:0] ram_q;

	logic                       vld_s4;
	logic                       rd_s4;
	logic                       playing_s4;
	pst_pkg::det_t              det_s4;

	// Resolve restart, next index and end of playback
	always_comb begin
		act      = det_s3.onset || active_q;
		idx0     = det_s3.onset ? '0 : idx_q;
		idx_inc  = idx0 + 1'b1;
		stop     = idx_inc >= sample_length;
		smp_go   = vld_s3 && !itm_s3.load;
		rd_en    = smp_go && act;
		we       = vld_s3 && itm_s3.load;
		ram_addr = we ? AW'(itm_s3.addr) : AW'(idx0);
	end

	pst_ram #(
		.WIDTH (pst_pkg::WORD_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.addr  (ram_addr),
		.wdata (itm_s3.value),
		.rdata (ram_q)
	);

	// Advance the play index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			active_q <= 1'b0;
			vld_s4   <= 1'b0;
		end else begin
			vld_s4 <= smp_go;
			if (rd_en) begin
				active_q <= !stop;
				idx_q    <= stop ? '0 : idx_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_s4      <= rd_en;
		playing_s4 <= act && !stop;
		det_s4     <= det_s3;
	end

	// Assemble the result, zero word when idle
	always_comb begin
		res_vld        = vld_s4;
		res.audio_word = rd_s4 ? ram_q : '0;
		res.playing    = playing_s4;
		res.onset      = det_s4.onset;
		res.peak_level = det_s4.peak;
	end

endmodule

>>> hdl/pst_out_fifo.sv
// ----------------------------------------------------------------------------
// pst_out_fifo
// Small result queue that parts the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module pst_out_fifo #(
	parameter int DEPTH = pst_pkg::OFIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pst_pkg::res_t din,
	output logic          out_vld,
	input  logic          out_rdy,
	output pst_pkg::res_t dout
);

	localparam int PW = $clog2(DEPTH);

	pst_pkg::res_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     cnt_q;
	logic            pop;

	assign out_vld = (cnt_q != '0);
	assign pop     = out_vld && out_rdy;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/piezo_onset_sample_trigger_unit.sv
// ----------------------------------------------------------------------------
// piezo_onset_sample_trigger_unit
// Piezo onset detector (DC blocker, peak tracker) that restarts playback of
// a stored sample; load items fill the sample store.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid / tready    tuser: action; tdata: sample, addr, value
//  m_*      out  tvalid / tready    tdata: audio_word, playing, onset, peak
//  apb      in   psel/penable/...   five config registers at 4*i
//
// One item per cycle sustained while tready is high; a sample result is
// offered after the input, filter, peak and store read registers and queue.
// The filter feedback multiply and the store read port each take one stage.
// STORE_DEPTH must be a power of two; the block does not enforce it. Reset
// clears all control and filter state; the store is not cleared. tready
// drops while eight sample results are outstanding in the pipeline or queue.
// ----------------------------------------------------------------------------
module piezo_onset_sample_trigger_unit #(
	parameter int STORE_DEPTH = pst_pkg::STORE_DEPTH_DEF,
	parameter int FRAC_BITS   = pst_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// piezo_sample [15:0], load_address [31:16], load_value [47:32]
	input  logic [pst_pkg::DATA_W-1:0]  s_tdata,
	// action [0]
	input  logic                        s_tuser,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// audio_word [15:0], playing [16], onset [17], peak_level [41:18], zeros
	output logic [pst_pkg::DATA_W-1:0]  m_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pst_pkg::APB_AW-1:0]  paddr,
	input  logic [pst_pkg::APB_DW-1:0]  pwdata,
	output logic [pst_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int CRW = $clog2(pst_pkg::OFIFO_DEPTH + 1);

	logic [pst_pkg::POLE_W-1:0] pole_q;
	logic [pst_pkg::LVL_W-1:0]  thr_q;
	logic [pst_pkg::LVL_W-1:0]  margin_q;
	logic [pst_pkg::LVL_W-1:0]  decay_q;
	logic [pst_pkg::LEN_W-1:0]  len_q;
	pst_pkg::reg_idx_t          reg_idx;
	logic                       cfg_wr;

	logic [CRW-1:0]             credit_q;
	logic                       take;
	logic                       take_smp;
	logic                       pop;

	logic                        vld_s2;
	pst_pkg::item_t              itm_s2;
	logic signed [FRAC_BITS+2:0] y;
	logic                        vld_s3;
	pst_pkg::item_t              itm_s3;
	pst_pkg::det_t               det_s3;
	logic                        res_vld;
	pst_pkg::res_t               res;
	pst_pkg::res_t               res_out;

	// Register file
	assign pready  = 1'b1;
	assign reg_idx = pst_pkg::reg_idx_t'(paddr[pst_pkg::APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q   <= pst_pkg::POLE_RST;
			thr_q    <= pst_pkg::THR_RST;
			margin_q <= pst_pkg::MARGIN_RST;
			decay_q  <= pst_pkg::DECAY_RST;
			len_q    <= pst_pkg::LEN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				pst_pkg::REG_POLE:   pole_q   <= pwdata[pst_pkg::POLE_W-1:0];
				pst_pkg::REG_THR:    thr_q    <= pwdata[pst_pkg::LVL_W-1:0];
				pst_pkg::REG_MARGIN: margin_q <= pwdata[pst_pkg::LVL_W-1:0];
				pst_pkg::REG_DECAY:  decay_q  <= pwdata[pst_pkg::LVL_W-1:0];
				pst_pkg::REG_LEN:    len_q    <= pwdata[pst_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pst_pkg::REG_POLE:   prdata = pst_pkg::APB_DW'(pole_q);
			pst_pkg::REG_THR:    prdata = pst_pkg::APB_DW'(thr_q);
			pst_pkg::REG_MARGIN: prdata = pst_pkg::APB_DW'(margin_q);
			pst_pkg::REG_DECAY:  prdata = pst_pkg::APB_DW'(decay_q);
			pst_pkg::REG_LEN:    prdata = pst_pkg::APB_DW'(len_q);
			default:             prdata = '0;
		endcase
	end

	// Credits for queue space: one per sample item in flight
	assign s_tready = (credit_q != '0);
	assign take     = s_tvalid && s_tready;
	assign take_smp = take && (s_tuser == pst_pkg::ACT_SAMPLE);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRW'(pst_pkg::OFIFO_DEPTH);
		end else begin
			case ({take_smp, pop})
				2'b10:   credit_q <= credit_q - 1'b1;
				2'b01:   credit_q <= credit_q + 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	pst_dc_filter #(
		.FRAC_BITS (FRAC_BITS)
	) u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.action       (s_tuser),
		.piezo_sample (s_tdata[15:0]),
		.load_address (s_tdata[31:16]),
		.load_value   (s_tdata[47:32]),
		.dc_pole      (pole_q),
		.vld_s2       (vld_s2),
		.itm_s2       (itm_s2),
		.y_q          (y)
	);

	pst_peak_track #(
		.FRAC_BITS (FRAC_BITS)
	) u_peak (
		.clk             (clk),
		.arst_n          (arst_n),
		.vld_s2          (vld_s2),
		.itm_s2          (itm_s2),
		.y               (y),
		.onset_threshold (thr_q),
		.drop_margin     (margin_q),
		.peak_decay      (decay_q),
		.vld_s3          (vld_s3),
		.itm_s3          (itm_s3),
		.det_s3          (det_s3)
	);

	pst_playback #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_play (
		.clk           (clk),
		.arst_n        (arst_n),
		.vld_s3        (vld_s3),
		.itm_s3        (itm_s3),
		.det_s3        (det_s3),
		.sample_length (len_q),
		.res_vld       (res_vld),
		.res           (res)
	);

	pst_out_fifo #(
		.DEPTH (pst_pkg::OFIFO_DEPTH)
	) u_ofifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_vld),
		.din     (res),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.dout    (res_out)
	);

	assign m_tdata = pst_pkg::DATA_W'(res_out);

endmodule

>>> hdl/pst_sva.sv
// ----------------------------------------------------------------------------
// pst_sva
// Port-level checker for the piezo onset sample trigger, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pst_sva (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [pst_pkg::DATA_W-1:0] m_tdata,
	input logic                       pready
);

	// Stalled result stays offered and unchanged
	`ASSERT_NEXT(a_m_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_m_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// An onset needs a peak above the level, so the peak is never zero
	`ASSERT_IMPLY(a_onset_peak, clk, arst_n, m_tvalid && m_tdata[17], m_tdata[41:18] != '0)

	// Register port never waits
	`ASSERT_IMPLY(a_pready, clk, arst_n, 1'b1, pready)

endmodule

bind piezo_onset_sample_trigger_unit pst_sva u_sva (.*);

>>> test/pst_onset_checker.sv
// ----------------------------------------------------------------------------
// pst_onset_checker
// Watches the item, result and register channels of the piezo onset sample
// trigger, predicts every result from its own copy of the filter, peak and
// playback state, and compares each result item field by field.
// ----------------------------------------------------------------------------
module pst_onset_checker import pst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic              s_tuser,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] m_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                mismatch_count,
	output int                results_due
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     SIG_BITS = FRAC_BITS_DEF + 3;
	localparam longint LVL_MAX  = (longint'(1) <<< (FRAC_BITS_DEF + 2)) - 1;
	localparam longint LVL_MIN  = -(longint'(1) <<< (FRAC_BITS_DEF + 2));

	// Register copies
	logic [POLE_W-1:0] pole;
	logic [LVL_W-1:0]  thr;
	logic [LVL_W-1:0]  margin;
	logic [LVL_W-1:0]  decay;
	logic [LEN_W-1:0]  clip_len;

	// Detector and playback state
	logic [SMP_W-1:0]           last_smp;
	logic signed [SIG_BITS-1:0] filt;
	logic [PEAK_W-1:0]          peak;
	logic                       fired;
	logic [LEN_W-1:0]           play_idx;
	logic                       play_on;
	logic signed [WORD_W-1:0]   clip [STORE_DEPTH_DEF];

	res_t playback_due [$];

	// Advance the DC blocker, peak tracker and playback by one sample item
	task automatic run_detector(input logic [SMP_W-1:0] smp, output res_t r);
		longint fb;
		longint mag;
		longint prod;
		longint y;
		longint lvl;
		longint pk;
		logic   onset_now;
		fb = longint'(filt);
		mag = (fb < 0) ? -fb : fb;
		prod = (mag * longint'(pole)) >>> 16;
		y = (longint'(smp) <<< (FRAC_BITS_DEF - SMP_W))
			- (longint'(last_smp) <<< (FRAC_BITS_DEF - SMP_W))
			+ ((fb < 0) ? -prod : prod);
		if (y > LVL_MAX) y = LVL_MAX;
		if (y < LVL_MIN) y = LVL_MIN;
		last_smp = smp;
		filt = y[SIG_BITS-1:0];

		// rectify, then follow rises or decay
		lvl = (y < 0) ? -y : y;
		if (lvl > LVL_MAX) lvl = LVL_MAX;
		pk = longint'(peak);
		if (lvl >= pk) begin
			pk = lvl;
			fired = 1'b0;
		end else if (pk >= longint'(decay)) begin
			pk = pk - longint'(decay);
		end
		peak = pk[PEAK_W-1:0];

		// fire once per peak and restart the clip
		onset_now = 1'b0;
		if (lvl < pk - longint'(margin) && pk >= longint'(thr) && !fired) begin
			fired = 1'b1;
			onset_now = 1'b1;
			play_idx = '0;
			play_on = 1'b1;
		end

		r = '0;
		if (play_on) begin
			r.audio_word = clip[play_idx % STORE_DEPTH_DEF];
			play_idx = play_idx + 1'b1;
			if (play_idx >= clip_len) begin
				play_on = 1'b0;
				play_idx = '0;
			end
		end
		r.playing = play_on;
		r.onset = onset_now;
		r.peak_level = peak;
	endtask

	task automatic note_field(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			pole = POLE_RST;
			thr = THR_RST;
			margin = MARGIN_RST;
			decay = DECAY_RST;
			clip_len = LEN_RST;
			last_smp = '0;
			filt = '0;
			peak = '0;
			fired = 1'b0;
			play_idx = '0;
			play_on = 1'b0;
			playback_due.delete();
			mismatch_count = 0;
			results_due = 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_POLE:   pole = pwdata[POLE_W-1:0];
					REG_THR:    thr = pwdata[LVL_W-1:0];
					REG_MARGIN: margin = pwdata[LVL_W-1:0];
					REG_DECAY:  decay = pwdata[LVL_W-1:0];
					REG_LEN:    clip_len = pwdata[LEN_W-1:0];
					default: ;
				endcase
			end

			// load items fill the clip, sample items queue a prediction
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_LOAD) begin
					clip[s_tdata[2*SMP_W-1:SMP_W]] = s_tdata[2*SMP_W+WORD_W-1:2*SMP_W];
				end else begin
					run_detector(s_tdata[SMP_W-1:0], want);
					playback_due.push_back(want);
				end
			end

			// compare each result item against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[$bits(res_t)-1:0]);
				if (playback_due.size() == 0) begin
					$display("%0t: result item expected none, got %h", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = playback_due.pop_front();
					note_field("audio_word", 32'(want.audio_word), 32'(got.audio_word));
					note_field("playing", 32'(want.playing), 32'(got.playing));
					note_field("onset", 32'(want.onset), 32'(got.onset));
					note_field("peak_level", 32'(want.peak_level), 32'(got.peak_level));
					note_field("pad bits", 32'd0, 32'(m_tdata[DATA_W-1:$bits(res_t)]));
				end
			end
			results_due = playback_due.size();
		end
	end

endmodule

>>> test/piezo_onset_sample_trigger_unit_tb.sv
// ----------------------------------------------------------------------------
// piezo_onset_sample_trigger_unit_tb
// Fills the low end of the clip store, runs short directed sequences over
// the register extremes, then random hits and noise under several register
// settings with random idling on both streams and one long result hold-off.
// A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module piezo_onset_sample_trigger_unit_tb;
	import pst_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD    = 10;
	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 240;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int FILL_WORDS     = 256;
	localparam int PHASE_ITEMS    = 55;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [DATA_W-1:0] s_tdata = '0;
	logic              s_tuser = ACT_SAMPLE;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int mismatch_count;
	int results_due;
	int items_offered = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	bit quiet_run = 1'b1;
	bit hold_request = 1'b0;

	piezo_onset_sample_trigger_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	pst_onset_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.m_tdata        (m_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Result side: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet_run || ($urandom_range(99) >= 32);
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (psel && penable && pready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one item, with a random gap first; returns at the accepting edge
	task automatic offer(input logic kind, input logic [DATA_W-1:0] word);
		int gap;
		gap = (!quiet_run && $urandom_range(99) < 22) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		items_offered++;
	endtask

	task automatic play(input logic [SMP_W-1:0] smp);
		offer(ACT_SAMPLE, {WORD_W'($urandom), SMP_W'($urandom), smp});
	endtask

	task automatic store_word(input logic [SMP_W-1:0] addr, input logic [WORD_W-1:0] val);
		offer(ACT_LOAD, {val, addr, SMP_W'($urandom)});
	endtask

	// Drop valid, wait for every result, then let the pipeline empty
	task automatic settle();
		@(negedge clk) s_tvalid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_all(input logic [APB_DW-1:0] pole, input logic [APB_DW-1:0] thr,
			input logic [APB_DW-1:0] margin, input logic [APB_DW-1:0] decay,
			input logic [APB_DW-1:0] len);
		apb_write(REG_POLE, pole);
		apb_write(REG_THR, thr);
		apb_write(REG_MARGIN, margin);
		apb_write(REG_DECAY, decay);
		apb_write(REG_LEN, len);
	endtask

	// Mostly hits (baseline, spike, settle back), some noise and loads
	task automatic random_phase(input int budget);
		int stop_at;
		logic [SMP_W-1:0] base;
		logic [SMP_W-1:0] spike;
		stop_at = items_offered + budget;
		while (items_offered < stop_at) begin
			case ($urandom_range(9))
				0, 1: repeat ($urandom_range(1, 8)) play(SMP_W'($urandom));
				2: store_word(SMP_W'($urandom), WORD_W'($urandom));
				default: begin
					base = SMP_W'($urandom);
					spike = SMP_W'($urandom);
					repeat ($urandom_range(1, 4)) play(base);
					repeat ($urandom_range(1, 3)) play(spike);
					repeat ($urandom_range(3, 30)) play(base ^ SMP_W'($urandom_range(0, 7)));
				end
			endcase
		end
	endtask

	initial begin
		logic [APB_DW-1:0] pole_pick;
		logic [WORD_W-1:0] fill_word;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Write the low clip entries once, with no idling; the play index
		// never runs past them, so playback never reads an unwritten word
		quiet_run = 1'b1;
		for (int a = 0; a < FILL_WORDS; a++) begin
			fill_word = (a == 0) ? 16'h7FFF : (a == 1) ? 16'h8000 : WORD_W'($urandom);
			store_word(SMP_W'(a), fill_word);
		end
		quiet_run = 1'b0;

		// Default tuning, short clip: idle output, onset, last word, mid load
		settle();
		set_all(APB_DW'(POLE_RST), APB_DW'(THR_RST), APB_DW'(MARGIN_RST),
			APB_DW'(DECAY_RST), 3);
		play(16'h0000);
		repeat (4) play(16'hFFFF);
		store_word(16'd2, 16'h1234);
		play(16'hFFFF);
		repeat (3) play(16'h0000);

		// Pole, threshold, margin and decay at zero, longest clip: retrigger
		settle();
		set_all(0, 0, 0, 0, 65536);
		play(16'hFFFF);
		play(16'hFFFF);
		play(16'h0000);
		play(16'h0000);
		play(16'h8000);

		// Zero-length clip still plays entry zero once
		settle();
		apb_write(REG_LEN, 0);
		play(16'h0000);
		repeat (3) play(16'hFFFF);

		// Upper extremes: no onset can reach the threshold
		settle();
		set_all(32'hFFFF, 32'd4194304, 32'd4194304, 32'd4194304, 1);
		play(16'h0000);
		play(16'hFFFF);
		play(16'h0000);

		// Random phases under varied tuning; one with a long result hold-off
		for (int p = 0; p < 6; p++) begin
			settle();
			case ($urandom_range(3))
				0: pole_pick = $urandom_range(0, 65535);
				1: pole_pick = APB_DW'(POLE_RST);
				2: pole_pick = $urandom_range(60000, 65535);
				default: pole_pick = 65535;
			endcase
			set_all(pole_pick, $urandom_range(0, 300000), $urandom_range(0, 100000),
				$urandom_range(0, 20000),
				(p == 4) ? $urandom_range(40000, 65536) : $urandom_range(0, 24));
			if (p == 2) hold_request = 1'b1;
			random_phase(PHASE_ITEMS);
		end

		settle();
		if (mismatch_count == 0 && results_due == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/pst_pkg.sv
hdl/pst_ram.sv
hdl/pst_dc_filter.sv
hdl/pst_peak_track.sv
hdl/pst_playback.sv
hdl/pst_out_fifo.sv
hdl/piezo_onset_sample_trigger_unit.sv
hdl/pst_sva.sv
test/pst_onset_checker.sv
test/piezo_onset_sample_trigger_unit_tb.sv
